@@ rtl/ilir_pkg.sv @@
package ilir_pkg;

  // Access codes carried in the mode field of a request.
  typedef enum logic [2:0] {
    MODE_LINK_WR    = 3'd0,
    MODE_STATUS_RD  = 3'd1,
    MODE_IRQ_EN_WR  = 3'd2,
    MODE_IRQ_RD     = 3'd3,
    MODE_FRAME_TICK = 3'd4
  } mode_e;

  // Commands recognized by the link decoder.
  localparam logic [3:0] CMD_READ8  = 4'h1;
  localparam logic [3:0] CMD_ID     = 4'h8;
  localparam logic [3:0] CMD_IGNORE = 4'hD;

  localparam logic [7:0]  LINK_ZERO_BYTE  = 8'h0C;
  localparam logic [7:0]  STATUS_IDLE     = 8'h02;
  localparam logic [7:0]  STATUS_MARK     = 8'hA5;
  localparam logic [7:0]  FRAME_IRQ_CODE  = 8'h08;
  localparam logic [15:0] ID_REPLY_WORD   = 16'h1039;
  localparam logic [4:0]  COLLECTOR_START = 5'd1;
  localparam int unsigned FRAME_EN_BIT    = 3;

  typedef struct packed {
    logic [4:0]  bit_collector;
    logic        awaiting_command;
    logic [4:0]  reply_bits_left;
    logic [15:0] reply_word;
    logic [23:0] status_shift;
    logic [7:0]  interrupt_enable;
    logic [7:0]  pending_interrupt;
  } state_t;

  localparam state_t STATE_RESET = '{
    bit_collector:     COLLECTOR_START,
    awaiting_command:  1'b1,
    reply_bits_left:   5'd0,
    reply_word:        16'd0,
    status_shift:      24'd0,
    interrupt_enable:  8'd0,
    pending_interrupt: 8'd0
  };

endpackage

@@ rtl/ilir_req_if.sv @@
interface ilir_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] data_in;

  modport source (output valid, output mode, output data_in, input ready);
  modport sink   (input valid, input mode, input data_in, output ready);
endinterface

@@ rtl/ilir_rsp_if.sv @@
interface ilir_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       interrupt_request;

  modport source (output valid, output read_data, output interrupt_request, input ready);
  modport sink   (input valid, input read_data, input interrupt_request, output ready);
endinterface

@@ rtl/ilir_core.sv @@
module ilir_core (
  input  ilir_pkg::state_t state_i,
  input  logic [2:0]       mode_i,
  input  logic [7:0]       data_i,
  output ilir_pkg::state_t state_o,
  output logic [7:0]       read_data_o,
  output logic             irq_o
);
  import ilir_pkg::*;

  logic [4:0]  col_shift;
  logic [4:0]  left_dec;
  logic        reply_bit;
  logic [15:0] status_rest;

  assign col_shift   = {state_i.bit_collector[3:0], (data_i != LINK_ZERO_BYTE)};
  assign left_dec    = state_i.reply_bits_left - 5'd1;
  assign reply_bit   = !left_dec[4] && state_i.reply_word[left_dec[3:0]];
  assign status_rest = state_i.status_shift[23:8];

  always_comb begin
    state_o     = state_i;
    read_data_o = 8'd0;
    irq_o       = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_LINK_WR: begin
        if (state_i.awaiting_command) begin
          if (data_i[3:2] == 2'b11) begin
            state_o.bit_collector = col_shift;
            if (col_shift[4]) begin
              // Four command bits are in: decode and start the reply.
              state_o.bit_collector    = COLLECTOR_START;
              state_o.awaiting_command = 1'b0;
              unique case (col_shift[3:0])
                CMD_READ8: begin
                  state_o.reply_word      = 16'd0;
                  state_o.reply_bits_left = 5'd8;
                end
                CMD_ID: begin
                  // Loads a reply but drops back to waiting, so it is never sent.
                  state_o.reply_word       = ID_REPLY_WORD;
                  state_o.reply_bits_left  = 5'd16;
                  state_o.awaiting_command = 1'b1;
                end
                CMD_IGNORE: begin
                  state_o.awaiting_command = 1'b1;
                end
                default: begin
                  state_o.reply_word      = 16'd0;
                  state_o.reply_bits_left = 5'd4;
                end
              endcase
            end
          end
        end else begin
          state_o.reply_bits_left = left_dec;
          state_o.status_shift    = {STATUS_MARK, reply_bit, 15'd0};
          if (left_dec == 5'd0) begin
            state_o.awaiting_command = 1'b1;
          end
        end
      end
      MODE_STATUS_RD: begin
        if (state_i.status_shift != 24'd0) begin
          read_data_o = state_i.status_shift[7:0];
          if (status_rest == {8'd0, STATUS_MARK}) begin
            state_o.status_shift = 24'd0;
          end else begin
            state_o.status_shift = {8'd0, status_rest};
          end
        end else begin
          read_data_o = STATUS_IDLE;
        end
      end
      MODE_IRQ_EN_WR: begin
        state_o.interrupt_enable = data_i;
      end
      MODE_IRQ_RD: begin
        read_data_o               = state_i.pending_interrupt;
        state_o.pending_interrupt = 8'd0;
      end
      MODE_FRAME_TICK: begin
        if (state_i.interrupt_enable[FRAME_EN_BIT]) begin
          state_o.pending_interrupt              = FRAME_IRQ_CODE;
          state_o.interrupt_enable[FRAME_EN_BIT] = 1'b0;
          irq_o                                  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/ipc_link_and_interrupt_regs.sv @@
// Serial co-processor link register and interrupt control register.
//
// Requests arrive on req_i (valid/ready), each carrying a mode and a data
// byte: link write, status read, interrupt enable write, interrupt read or
// frame tick. Every request produces exactly one response on rsp_o with the
// byte read (zero for modes that do not read) and an interrupt request flag
// that is set only by a frame tick that raised the frame interrupt.
//
// A request is captured in an input register, evaluated against the block
// state by combinational logic, and its response is held in an output
// register. A response becomes valid once its request has passed from the
// input register into the output register, and one request is accepted in
// every cycle while the response side keeps taking results.
//
// When the receiver stalls, the response register holds its value, the
// captured request waits in the input register, and req_i.ready drops once
// that register is occupied. No state changes while a request waits.
//
// Reset empties both pipeline registers and returns the link to waiting for
// a command with an empty collector, no reply prepared, interrupts disabled
// and nothing pending.
module ipc_link_and_interrupt_regs (
  input  logic      clk_i,
  input  logic      rst_ni,
  ilir_req_if.sink  req_i,
  ilir_rsp_if.source rsp_o
);
  import ilir_pkg::*;

  // Input register.
  logic       req_valid_q;
  logic [2:0] req_mode_q;
  logic [7:0] req_data_q;

  // Response register.
  logic       rsp_valid_q;
  logic [7:0] rsp_data_q;
  logic       rsp_irq_q;

  // Block state.
  state_t state_q;
  state_t state_d;
  logic [7:0] read_data_d;
  logic       irq_d;

  logic advance;
  logic req_fire;

  // The captured request moves on when the response register is free or is
  // being emptied in this cycle.
  assign advance     = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || advance;
  assign req_fire    = req_i.valid && req_i.ready;

  ilir_core u_core (
    .state_i     (state_q),
    .mode_i      (req_mode_q),
    .data_i      (req_data_q),
    .state_o     (state_d),
    .read_data_o (read_data_d),
    .irq_o       (irq_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_mode_q <= req_i.mode;
      req_data_q <= req_i.data_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_data_q <= read_data_d;
      rsp_irq_q  <= irq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign rsp_o.valid             = rsp_valid_q;
  assign rsp_o.read_data         = rsp_data_q;
  assign rsp_o.interrupt_request = rsp_irq_q;

  // The start marker never leaves the collector.
  a_collector_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bit_collector != 5'd0)
    else $error("bit collector lost its start marker");

  // While replying there is always at least one reply bit left.
  a_reply_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.awaiting_command |-> state_q.reply_bits_left != 5'd0)
    else $error("reply state with no reply bits left");

  // The top status byte is either empty or the fixed marker.
  a_status_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.status_shift[23:16] == 8'd0 || state_q.status_shift[23:16] == STATUS_MARK)
    else $error("status shift holds a corrupt top byte");

  // A raised interrupt leaves the frame code pending and the frame enable cleared.
  a_irq_effect : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && irq_d |=> state_q.pending_interrupt == FRAME_IRQ_CODE
      && !state_q.interrupt_enable[FRAME_EN_BIT] && rsp_irq_q && rsp_data_q == 8'd0)
    else $error("frame interrupt did not update the interrupt registers");

endmodule
